// ===== rtl/core/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types and constants for the polygon ring centroid block.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int XY_W   = 16;
    localparam int REL_W  = 17;
    localparam int SUM_W  = 18;
    localparam int OUT_W  = 24;
    localparam int CNT_W  = 11;
    localparam int AREA_W = 46;
    localparam int MOM_W  = 64;
    localparam int CSUM_W = 27;
    localparam int MIN_W  = 20;
    localparam int D_W    = 35;
    localparam int DLO_W  = 18;
    localparam int MUL_W  = 19;
    localparam int PROD_W = 38;
    localparam int DIVN_W = 72;
    localparam int DIVD_W = 48;
    localparam int QCL_W  = 26;
    localparam int QC_W   = 28;
    localparam int FRAC_W = 8;

    localparam logic signed [QC_W-1:0] SAT_HI = 28'sd8388607;
    localparam logic signed [QC_W-1:0] SAT_LO = -28'sd8388608;

    typedef enum logic [1:0] {
        KIND_EMPTY  = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_AREA   = 2'd2,
        KIND_DEGEN  = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_P1, ST_P2, ST_D, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
        ST_FIN, ST_DIVX_GO, ST_DIVX_RUN, ST_DIVY_GO, ST_DIVY_RUN, ST_PUBLISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_EMPTY, OP_SKIP, OP_FIRST, OP_REL,
        OP_P1, OP_P2, OP_D, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5,
        OP_FIN, OP_DIV_X, OP_DIV_Y, OP_RES_X, OP_RES_Y, OP_PUBLISH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
        logic full;
        logic seen_zero;
        logic seen_le1;
        logic div_busy;
        logic out_busy;
    } status_t;

endpackage

// ===== rtl/core/prc_if.sv =====
// ----------------------------------------------------------------------------
// prc_if
// Valid/ready channels for vertex input and centroid output.
// ----------------------------------------------------------------------------
interface prc_vertex_if import prc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [XY_W-1:0]  vx;
    logic signed [XY_W-1:0]  vy;
    logic                    last;
    logic                    empty_ring;

    modport source (output valid, vx, vy, last, empty_ring, input ready);
    modport sink   (input valid, vx, vy, last, empty_ring, output ready);
endinterface

interface prc_cent_if import prc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] cent_x;
    logic signed [OUT_W-1:0] cent_y;
    logic [1:0]              kind;
    logic                    overflowed;
    logic [CNT_W-1:0]        vertex_total;

    modport source (output valid, cent_x, cent_y, kind, overflowed, vertex_total,
                    input ready);
    modport sink   (input valid, cent_x, cent_y, kind, overflowed, vertex_total,
                    output ready);
endinterface

// ===== rtl/core/prc_divider.sv =====
// ----------------------------------------------------------------------------
// prc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prc_divider import prc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVN_W-1:0] dividend,
    input  logic [DIVD_W-1:0] divisor,
    output logic              busy,
    output logic [DIVN_W-1:0] quotient,
    output logic              rem_nz
);

    localparam int STEP_W = $clog2(DIVN_W);

    logic [DIVN_W-1:0] quo_reg;
    logic [DIVD_W-1:0] rem_reg;
    logic [DIVD_W-1:0] div_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic [DIVD_W:0]   trial;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DIVN_W-1]};
    assign ge    = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(DIVN_W - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVN_W-2:0], ge};
            rem_reg <= ge ? DIVD_W'(trial - {1'b0, div_reg}) : DIVD_W'(trial);
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
    assign rem_nz   = |rem_reg;

endmodule

// ===== rtl/core/prc_datapath.sv =====
// ----------------------------------------------------------------------------
// prc_datapath
// Ring accumulators, shared multiplier, result formatting and output register.
// ----------------------------------------------------------------------------
module prc_datapath import prc_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic signed [XY_W-1:0]  vx,
    input  logic signed [XY_W-1:0]  vy,
    input  logic                    last,
    input  logic                    empty_ring,
    input  logic                    cfg_we,
    input  logic [MIN_W-1:0]        cfg_wdata,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] cent_x,
    output logic signed [OUT_W-1:0] cent_y,
    output logic [1:0]              kind,
    output logic                    overflowed,
    output logic [CNT_W-1:0]        vertex_total
);

    logic [MIN_W-1:0]         min_area_reg;
    logic signed [XY_W-1:0]   x_reg, y_reg;
    logic                     last_reg, empty_reg;
    logic signed [XY_W-1:0]   first_x_reg, first_y_reg;
    logic signed [REL_W-1:0]  prel_x_reg, prel_y_reg, rel_x_reg, rel_y_reg;
    logic signed [SUM_W-1:0]  sx_reg, sy_reg;
    logic [CNT_W-1:0]         seen_reg;
    logic signed [AREA_W-1:0] area_reg;
    logic signed [MOM_W-1:0]  mom_x_reg, mom_y_reg;
    logic signed [CSUM_W-1:0] csum_x_reg, csum_y_reg;
    logic                     too_many_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [D_W-1:0]    t_reg, d_reg;
    kind_t                    kind_reg;
    logic signed [OUT_W-1:0]  res_x_reg, res_y_reg;
    logic                     neg_reg;
    logic signed [XY_W-1:0]   base_reg;
    logic                     out_valid_reg;

    logic signed [XY_W-1:0]   x_ext, y_ext;
    logic signed [MUL_W-1:0]  mul_a, mul_b, d_lo, d_hi;
    logic                     clr;
    logic                     area_low;
    logic                     seen_le1;
    logic                     div_start, div_busy, rem_nz;
    logic [DIVN_W-1:0]        dividend, quotient;
    logic [DIVD_W-1:0]        divisor;
    logic signed [OUT_W-1:0]  res_calc;

    assign x_ext    = XY_W'(signed'(vx[COORD_BITS-1:0]));
    assign y_ext    = XY_W'(signed'(vy[COORD_BITS-1:0]));
    assign clr      = (cmd.op == OP_EMPTY) || (cmd.op == OP_PUBLISH);
    assign area_low = area_reg < signed'({{(AREA_W-MIN_W){1'b0}}, min_area_reg});
    assign seen_le1 = seen_reg <= CNT_W'(1);
    assign d_lo     = signed'({1'b0, d_reg[DLO_W-1:0]});
    assign d_hi     = MUL_W'(signed'(d_reg[D_W-1:DLO_W]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_area_reg <= MIN_W'(1);
        else if (cfg_we)
            min_area_reg <= cfg_wdata;
    end

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_P1:
            begin
                mul_a = MUL_W'(prel_x_reg);
                mul_b = MUL_W'(rel_y_reg);
            end
            OP_P2:
            begin
                mul_a = MUL_W'(rel_x_reg);
                mul_b = MUL_W'(prel_y_reg);
            end
            OP_M1:
            begin
                mul_a = MUL_W'(sx_reg);
                mul_b = d_lo;
            end
            OP_M2:
            begin
                mul_a = MUL_W'(sx_reg);
                mul_b = d_hi;
            end
            OP_M3:
            begin
                mul_a = MUL_W'(sy_reg);
                mul_b = d_lo;
            end
            OP_M4:
            begin
                mul_a = MUL_W'(sy_reg);
                mul_b = d_hi;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_LOAD:
            begin
                x_reg     <= x_ext;
                y_reg     <= y_ext;
                last_reg  <= last;
                empty_reg <= empty_ring;
            end
            OP_REL:
            begin
                rel_x_reg <= REL_W'(x_reg) - REL_W'(first_x_reg);
                rel_y_reg <= REL_W'(y_reg) - REL_W'(first_y_reg);
            end
            OP_P1:
            begin
                sx_reg <= SUM_W'(prel_x_reg) + SUM_W'(rel_x_reg);
                sy_reg <= SUM_W'(prel_y_reg) + SUM_W'(rel_y_reg);
            end
            OP_P2:    t_reg <= D_W'(prod_reg);
            OP_D:     d_reg <= t_reg - D_W'(prod_reg);
            OP_DIV_X:
            begin
                neg_reg  <= dividend_sign(1'b0);
                base_reg <= first_x_reg;
            end
            OP_DIV_Y:
            begin
                neg_reg  <= dividend_sign(1'b1);
                base_reg <= first_y_reg;
            end
            default:
            begin
            end
        endcase
    end

    // ring accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg  <= '0;
            first_y_reg  <= '0;
            prel_x_reg   <= '0;
            prel_y_reg   <= '0;
            seen_reg     <= '0;
            area_reg     <= '0;
            mom_x_reg    <= '0;
            mom_y_reg    <= '0;
            csum_x_reg   <= '0;
            csum_y_reg   <= '0;
            too_many_reg <= 1'b0;
            kind_reg     <= KIND_EMPTY;
            res_x_reg    <= '0;
            res_y_reg    <= '0;
        end
        else if (clr)
        begin
            first_x_reg  <= '0;
            first_y_reg  <= '0;
            prel_x_reg   <= '0;
            prel_y_reg   <= '0;
            seen_reg     <= '0;
            area_reg     <= '0;
            mom_x_reg    <= '0;
            mom_y_reg    <= '0;
            csum_x_reg   <= '0;
            csum_y_reg   <= '0;
            too_many_reg <= 1'b0;
            if (cmd.op == OP_EMPTY)
            begin
                kind_reg  <= KIND_EMPTY;
                res_x_reg <= '0;
                res_y_reg <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                OP_SKIP: too_many_reg <= 1'b1;
                OP_FIRST:
                begin
                    first_x_reg <= x_reg;
                    first_y_reg <= y_reg;
                    prel_x_reg  <= '0;
                    prel_y_reg  <= '0;
                    csum_x_reg  <= csum_x_reg + CSUM_W'(x_reg);
                    csum_y_reg  <= csum_y_reg + CSUM_W'(y_reg);
                    seen_reg    <= seen_reg + 1'b1;
                end
                OP_REL:
                begin
                    csum_x_reg <= csum_x_reg + CSUM_W'(x_reg);
                    csum_y_reg <= csum_y_reg + CSUM_W'(y_reg);
                    seen_reg   <= seen_reg + 1'b1;
                end
                OP_M2: mom_x_reg <= mom_x_reg + MOM_W'(prod_reg);
                OP_M3: mom_x_reg <= mom_x_reg + (MOM_W'(prod_reg) <<< DLO_W);
                OP_M4: mom_y_reg <= mom_y_reg + MOM_W'(prod_reg);
                OP_M5:
                begin
                    mom_y_reg  <= mom_y_reg + (MOM_W'(prod_reg) <<< DLO_W);
                    area_reg   <= area_reg + AREA_W'(d_reg);
                    prel_x_reg <= rel_x_reg;
                    prel_y_reg <= rel_y_reg;
                end
                OP_FIN:
                begin
                    if (seen_le1)
                        kind_reg <= KIND_SINGLE;
                    else if (area_low)
                        kind_reg <= KIND_DEGEN;
                    else
                        kind_reg <= KIND_AREA;
                    res_x_reg <= OUT_W'(first_x_reg) <<< FRAC_W;
                    res_y_reg <= OUT_W'(first_y_reg) <<< FRAC_W;
                end
                OP_RES_X: res_x_reg <= res_calc;
                OP_RES_Y: res_y_reg <= res_calc;
                default:
                begin
                end
            endcase
        end
    end

    function automatic logic signed [MOM_W-1:0] axis_num(input logic axis_y);
        logic signed [CSUM_W-1:0] deg;
        begin
            if (axis_y)
                deg = csum_y_reg - CSUM_W'(first_y_reg) - CSUM_W'(prel_y_reg);
            else
                deg = csum_x_reg - CSUM_W'(first_x_reg) - CSUM_W'(prel_x_reg);
            if (kind_reg == KIND_AREA)
                axis_num = axis_y ? mom_y_reg : mom_x_reg;
            else
                axis_num = MOM_W'(deg);
        end
    endfunction

    function automatic logic dividend_sign(input logic axis_y);
        logic signed [MOM_W-1:0] c;
        begin
            c = axis_num(axis_y);
            dividend_sign = c[MOM_W-1];
        end
    endfunction

    // divider operands
    always_comb
    begin
        logic signed [MOM_W-1:0] c;
        logic [MOM_W-1:0]        mag;
        logic [DIVD_W-1:0]       a3;
        c         = axis_num(cmd.op == OP_DIV_Y);
        mag       = c[MOM_W-1] ? (~c + 1'b1) : c;
        dividend  = {mag, {FRAC_W{1'b0}}};
        a3        = DIVD_W'(unsigned'(area_reg));
        if (kind_reg == KIND_AREA)
            divisor = a3 + (a3 << 1);
        else
            divisor = DIVD_W'(seen_reg - 1'b1);
        div_start = (cmd.op == OP_DIV_X) || (cmd.op == OP_DIV_Y);
    end

    prc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient),
        .rem_nz   (rem_nz)
    );

    // quotient to Q16.8, trunc toward zero, saturated
    always_comb
    begin
        logic [QCL_W-1:0]       qc;
        logic signed [QC_W-1:0] qs, v;
        qc = (|quotient[DIVN_W-1:QCL_W]) ? {QCL_W{1'b1}} : quotient[QCL_W-1:0];
        qs = signed'(QC_W'(qc));
        if (kind_reg == KIND_AREA)
        begin
            v = neg_reg ? (-qs - QC_W'(rem_nz)) : qs;
            v = (QC_W'(base_reg) <<< FRAC_W) + v;
            if (rem_nz && v < 0)
                v = v + QC_W'(1);
        end
        else
            v = neg_reg ? -qs : qs;
        if (v > SAT_HI)
            v = SAT_HI;
        else if (v < SAT_LO)
            v = SAT_LO;
        res_calc = OUT_W'(v);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_PUBLISH)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PUBLISH)
        begin
            cent_x       <= res_x_reg;
            cent_y       <= res_y_reg;
            kind         <= kind_reg;
            overflowed   <= too_many_reg;
            vertex_total <= seen_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status.empty     = empty_reg;
    assign status.last      = last_reg;
    assign status.full      = seen_reg >= CNT_W'(MAX_VERTICES);
    assign status.seen_zero = seen_reg == '0;
    assign status.seen_le1  = seen_le1;
    assign status.div_busy  = div_busy;
    assign status.out_busy  = out_valid_reg && !out_ready;

endmodule

// ===== rtl/core/prc_ctrl.sv =====
// ----------------------------------------------------------------------------
// prc_ctrl
// Sequencer for vertex accumulation, final division and result hand-off.
// ----------------------------------------------------------------------------
module prc_ctrl import prc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (status.empty)
                    state_next = ST_PUBLISH;
                else if (status.full || status.seen_zero)
                    state_next = status.last ? ST_FIN : ST_IDLE;
                else
                    state_next = ST_P1;
            end
            ST_P1:       state_next = ST_P2;
            ST_P2:       state_next = ST_D;
            ST_D:        state_next = ST_M1;
            ST_M1:       state_next = ST_M2;
            ST_M2:       state_next = ST_M3;
            ST_M3:       state_next = ST_M4;
            ST_M4:       state_next = ST_M5;
            ST_M5:       state_next = status.last ? ST_FIN : ST_IDLE;
            ST_FIN:      state_next = status.seen_le1 ? ST_PUBLISH : ST_DIVX_GO;
            ST_DIVX_GO:  state_next = ST_DIVX_RUN;
            ST_DIVX_RUN: if (!status.div_busy) state_next = ST_DIVY_GO;
            ST_DIVY_GO:  state_next = ST_DIVY_RUN;
            ST_DIVY_RUN: if (!status.div_busy) state_next = ST_PUBLISH;
            ST_PUBLISH:  if (!status.out_busy) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = OP_LOAD;
            end
            ST_CHECK:
            begin
                if (status.empty)
                    cmd.op = OP_EMPTY;
                else if (status.full)
                    cmd.op = OP_SKIP;
                else if (status.seen_zero)
                    cmd.op = OP_FIRST;
                else
                    cmd.op = OP_REL;
            end
            ST_P1:       cmd.op = OP_P1;
            ST_P2:       cmd.op = OP_P2;
            ST_D:        cmd.op = OP_D;
            ST_M1:       cmd.op = OP_M1;
            ST_M2:       cmd.op = OP_M2;
            ST_M3:       cmd.op = OP_M3;
            ST_M4:       cmd.op = OP_M4;
            ST_M5:       cmd.op = OP_M5;
            ST_FIN:      cmd.op = OP_FIN;
            ST_DIVX_GO:  cmd.op = OP_DIV_X;
            ST_DIVX_RUN: if (!status.div_busy) cmd.op = OP_RES_X;
            ST_DIVY_GO:  cmd.op = OP_DIV_Y;
            ST_DIVY_RUN: if (!status.div_busy) cmd.op = OP_RES_Y;
            ST_PUBLISH:  if (!status.out_busy) cmd.op = OP_PUBLISH;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/core/polygon_ring_centroid_top.sv =====
// ----------------------------------------------------------------------------
// polygon_ring_centroid_top
// Shoelace centroid of one polygon ring streamed as vertex transactions.
// ----------------------------------------------------------------------------
// One vertex transaction at a time. A first or ignored vertex is only loaded
// and checked; every further vertex sends two cross and four moment products
// through one shared 19x19 multiplier, the 35-bit edge term split in halves.
// A ring end with two or more vertices adds two 72-step restoring divisions
// (x then y) before the result lands in the output register; the next vertex
// can be taken while that result waits. An empty ring publishes a cleared one.
// ----------------------------------------------------------------------------
module polygon_ring_centroid_top import prc_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    prc_vertex_if.sink       vertex,
    prc_cent_if.source       centroid,
    input  logic             cfg_we,
    input  logic [MIN_W-1:0] cfg_wdata
);

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    assign vertex.ready = in_ready;

    prc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vertex.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    prc_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .vx           (vertex.vx),
        .vy           (vertex.vy),
        .last         (vertex.last),
        .empty_ring   (vertex.empty_ring),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (centroid.valid),
        .out_ready    (centroid.ready),
        .cent_x       (centroid.cent_x),
        .cent_y       (centroid.cent_y),
        .kind         (centroid.kind),
        .overflowed   (centroid.overflowed),
        .vertex_total (centroid.vertex_total)
    );

endmodule

// ===== rtl/core/prc_checker.sv =====
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks for the polygon ring centroid block.
// ----------------------------------------------------------------------------
module prc_checker import prc_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [OUT_W-1:0] cent_x,
    input logic signed [OUT_W-1:0] cent_y,
    input logic [1:0]              kind,
    input logic                    overflowed,
    input logic [CNT_W-1:0]        vertex_total
);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken on back-to-back cycles");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_EMPTY) |->
        (cent_x == '0 && cent_y == '0 && vertex_total == '0 && !overflowed))
        else $error("empty ring result not cleared");

    a_single_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_SINGLE) |-> (vertex_total == CNT_W'(1)))
        else $error("single vertex result with wrong count");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(cent_x) && $stable(cent_y) && $stable(kind)))
        else $error("stalled result changed");

endmodule

bind polygon_ring_centroid_top prc_checker u_prc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (vertex.valid),
    .in_ready     (vertex.ready),
    .out_valid    (centroid.valid),
    .out_ready    (centroid.ready),
    .cent_x       (centroid.cent_x),
    .cent_y       (centroid.cent_y),
    .kind         (centroid.kind),
    .overflowed   (centroid.overflowed),
    .vertex_total (centroid.vertex_total)
);

// ===== sim/prc_tb_if.sv =====
// ----------------------------------------------------------------------------
// prc_tb_if
// Testbench note: the vertex and centroid channels are the RTL interfaces
// prc_vertex_if and prc_cent_if; this file holds the helper types the bench
// shares between its driver and its monitor.
// ----------------------------------------------------------------------------
package prc_tb_pkg;
    import prc_pkg::*;

    typedef struct {
        logic signed [XY_W-1:0] vx;
        logic signed [XY_W-1:0] vy;
        logic                   last;
        logic                   empty_ring;
    } vertex_txn_t;

    typedef struct {
        logic signed [OUT_W-1:0] cent_x;
        logic signed [OUT_W-1:0] cent_y;
        kind_t                   kind;
        logic                    overflowed;
        logic [CNT_W-1:0]        vertex_total;
    } centroid_txn_t;
endpackage

// ===== sim/polygon_ring_centroid_top_tb.sv =====
// ----------------------------------------------------------------------------
// polygon_ring_centroid_top_tb
// Streams directed and random polygon rings into the centroid block, predicts
// each ring result with a behavioral shoelace model and checks every centroid
// transaction field by field, under random bursts, stalls and min_area settings.
// ----------------------------------------------------------------------------
module polygon_ring_centroid_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import prc_pkg::*;
    import prc_tb_pkg::*;

    localparam int MAXV = 1024;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [MIN_W-1:0] cfg_wdata = '0;

    prc_vertex_if vtx();
    prc_cent_if   cen();

    polygon_ring_centroid_top #(.MAX_VERTICES(MAXV), .COORD_BITS(16)) dut (
        .clk(clk), .rst_n(rst_n), .vertex(vtx), .centroid(cen),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    vertex_txn_t   pending_vertices[$];
    centroid_txn_t expected_centroids[$];
    int  error_count = 0;
    int  hold_off_cycles = 0;
    bit  sender_pause = 1'b0;

    // ring accumulator
    logic [MIN_W-1:0] area_floor;
    longint fx, fy, prx, pry, area_acc, mom_x, mom_y, csx, csy;
    int     vcount;
    bit     vdropped;

    function automatic longint sat24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint weighted_q8(longint base, longint c, longint d);
        longint q, r, f, lo;
        q = c / d;
        r = c % d;
        if (q > 100000 || q < -100000) return (q > 0) ? 8388607 : -8388608;
        f = (r * 256) / d;
        if ((r * 256) % d != 0 && r < 0) f = f - 1;
        lo = (base + q) * 256 + f;
        if ((r * 256) % d != 0 && lo < 0) lo = lo + 1;
        return sat24(lo);
    endfunction

    task automatic clear_ring();
        fx = 0; fy = 0; prx = 0; pry = 0; area_acc = 0;
        mom_x = 0; mom_y = 0; csx = 0; csy = 0; vcount = 0; vdropped = 0;
    endtask

    task automatic predict_centroid(vertex_txn_t t);
        centroid_txn_t r;
        longint x, y, rx, ry, d, n1;
        if (t.empty_ring)
        begin
            clear_ring();
            r.cent_x = '0; r.cent_y = '0; r.kind = KIND_EMPTY;
            r.overflowed = 1'b0; r.vertex_total = '0;
            expected_centroids.push_back(r);
            return;
        end
        if (vcount >= MAXV)
            vdropped = 1;
        else
        begin
            x = t.vx;
            y = t.vy;
            if (vcount == 0)
            begin
                fx = x; fy = y; prx = 0; pry = 0;
            end
            else
            begin
                rx = x - fx;
                ry = y - fy;
                d = prx * ry - rx * pry;
                area_acc += d;
                mom_x += (prx + rx) * d;
                mom_y += (pry + ry) * d;
                prx = rx;
                pry = ry;
            end
            csx += x;
            csy += y;
            vcount++;
        end
        if (!t.last) return;
        if (vcount <= 1)
        begin
            r.cent_x = OUT_W'(sat24(fx * 256));
            r.cent_y = OUT_W'(sat24(fy * 256));
            r.kind = KIND_SINGLE;
        end
        else if (area_acc < longint'(area_floor))
        begin
            n1 = vcount - 1;
            r.cent_x = OUT_W'(sat24(((csx - (fx + prx)) * 256) / n1));
            r.cent_y = OUT_W'(sat24(((csy - (fy + pry)) * 256) / n1));
            r.kind = KIND_DEGEN;
        end
        else
        begin
            r.cent_x = OUT_W'(weighted_q8(fx, mom_x, 3 * area_acc));
            r.cent_y = OUT_W'(weighted_q8(fy, mom_y, 3 * area_acc));
            r.kind = KIND_AREA;
        end
        r.overflowed = vdropped;
        r.vertex_total = vcount[CNT_W-1:0];
        expected_centroids.push_back(r);
        clear_ring();
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx.valid <= 1'b0;
            vtx.vx <= '0; vtx.vy <= '0; vtx.last <= 1'b0; vtx.empty_ring <= 1'b0;
        end
        else if (!vtx.valid || vtx.ready)
        begin
            if (vtx.valid)
            begin
                predict_centroid(pending_vertices.pop_front());
            end
            if (gap_left > 0)
            begin
                gap_left--;
                vtx.valid <= 1'b0;
            end
            else if (pending_vertices.size() != 0 && !sender_pause)
            begin
                vtx.valid <= 1'b1;
                vtx.vx <= pending_vertices[0].vx;
                vtx.vy <= pending_vertices[0].vy;
                vtx.last <= pending_vertices[0].last;
                vtx.empty_ring <= pending_vertices[0].empty_ring;
                if (burst_left > 0) burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
                end
            end
            else
                vtx.valid <= 1'b0;
        end
    end

    // driver holds the front item until accepted; peek used above
    // monitor with its own stall pattern
    logic [7:0] stall_pat;
    int stall_phase = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen.ready <= 1'b0;
            stall_pat <= 8'hff;
        end
        else
        begin
            if (cen.valid && cen.ready)
            begin
                if (expected_centroids.size() == 0)
                begin
                    report_mismatch("unexpected centroid transaction", 1, 0);
                end
                else
                begin
                    centroid_txn_t e;
                    e = expected_centroids.pop_front();
                    if (cen.cent_x !== e.cent_x) report_mismatch("cent_x", cen.cent_x, e.cent_x);
                    if (cen.cent_y !== e.cent_y) report_mismatch("cent_y", cen.cent_y, e.cent_y);
                    if (cen.kind !== e.kind) report_mismatch("kind", cen.kind, e.kind);
                    if (cen.overflowed !== e.overflowed)
                        report_mismatch("overflowed", cen.overflowed, e.overflowed);
                    if (cen.vertex_total !== e.vertex_total)
                        report_mismatch("vertex_total", cen.vertex_total, e.vertex_total);
                end
            end
            stall_phase = (stall_phase + 1) % 64;
            if (stall_phase == 0)
                stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                cen.ready <= 1'b0;
            end
            else
                cen.ready <= stall_pat[stall_phase % 8];
        end
    end

    task automatic add_vertex(int x, int y, bit lst);
        vertex_txn_t t;
        t.vx = XY_W'(x); t.vy = XY_W'(y); t.last = lst; t.empty_ring = 1'b0;
        pending_vertices.push_back(t);
    endtask

    task automatic add_empty(int x, int y, bit lst);
        vertex_txn_t t;
        t.vx = XY_W'(x); t.vy = XY_W'(y); t.last = lst; t.empty_ring = 1'b1;
        pending_vertices.push_back(t);
    endtask

    task automatic add_random_ring(int n, int span);
        int cx, cy, i, rad;
        cx = $urandom_range(0, 65535) - 32768;
        cy = $urandom_range(0, 65535) - 32768;
        cx = cx / (span == 32767 ? 1 : 4);
        cy = cy / (span == 32767 ? 1 : 4);
        for (i = 0; i < n; i++)
        begin
            rad = $urandom_range(0, span);
            if ($urandom_range(0, 3) == 0)
                add_vertex($urandom_range(0, 65535) - 32768,
                           $urandom_range(0, 65535) - 32768, i == n - 1);
            else
                add_vertex(cx + ((i * 7 % 5) - 2) * rad / 2, cy + ((i * 3 % 4) - 2) * rad / 2,
                           i == n - 1);
        end
    endtask

    task automatic drain();
        while (pending_vertices.size() != 0 || vtx.valid)
            @(posedge clk);
        sender_pause = 1'b1;
        while (expected_centroids.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        sender_pause = 1'b0;
    endtask

    task automatic write_min_area(logic [MIN_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        area_floor = v;
    endtask

    initial
    begin
        int i, k;
        clear_ring();
        area_floor = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        add_empty(-5, 9, 1);
        add_vertex(32767, -32768, 1);
        add_vertex(-32768, 32767, 1);
        add_vertex(0, 0, 0); add_vertex(100, 0, 0); add_vertex(100, 100, 0);
        add_vertex(0, 100, 1);
        add_vertex(0, 0, 0); add_vertex(0, 100, 0); add_vertex(100, 100, 1);
        add_vertex(-32768, -32768, 0); add_vertex(32767, -32768, 0);
        add_vertex(32767, 32767, 0); add_vertex(-32768, 32767, 1);
        add_vertex(3, 3, 0); add_vertex(6, 6, 0); add_empty(1, 1, 0);
        add_vertex(5, -7, 0); add_vertex(5, -7, 1);
        drain();

        write_min_area(20'hFFFFF);
        add_vertex(0, 0, 0); add_vertex(100, 0, 0); add_vertex(0, 100, 1);
        drain();
        write_min_area(MIN_W'(1));
        add_vertex(1, 1, 0); add_vertex(2, 2, 0); add_vertex(3, 3, 1);
        for (i = 0; i < MAXV + 3; i++)
            add_vertex(i % 2 ? 50 : -50, (i % 3) * 40, i == MAXV + 2);
        drain();

        // receiver holds off while the sender keeps offering
        hold_off_cycles = 600;
        for (i = 0; i < 20; i++) add_random_ring(3, 200);
        drain();

        for (k = 0; k < 5; k++)
        begin
            case (k)
                0: write_min_area(MIN_W'(1));
                1: write_min_area(MIN_W'($urandom_range(1, 5000)));
                2: write_min_area(20'hFFFFF);
                3: write_min_area(MIN_W'(2));
                default: write_min_area(MIN_W'($urandom_range(1, 1048575)));
            endcase
            i = 0;
            while (i < 110)
            begin
                case ($urandom_range(0, 9))
                    0: begin add_empty($urandom, $urandom, $urandom_range(0, 1)); i++; end
                    1: begin add_vertex($urandom, $urandom, 1); i++; end
                    2: begin add_random_ring(6, 32767); i += 6; end
                    default:
                    begin
                        int n;
                        n = $urandom_range(2, 9);
                        add_random_ring(n, $urandom_range(0, 1) ? 30 : 3000);
                        i += n;
                    end
                endcase
            end
            drain();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/prc_pkg.sv
rtl/core/prc_if.sv
rtl/core/prc_divider.sv
rtl/core/prc_datapath.sv
rtl/core/prc_ctrl.sv
rtl/core/polygon_ring_centroid_top.sv
rtl/core/prc_checker.sv
sim/prc_tb_if.sv
sim/polygon_ring_centroid_top_tb.sv
